>>> src/ep2cal_pkg.sv
package ep2cal_pkg;

  localparam int unsigned InW     = 31;
  localparam int unsigned SecsW   = 32;
  localparam int unsigned DaysW   = 15;
  localparam int unsigned YearW   = 11;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned YoffW   = 7;

  localparam logic [SecsW-1:0] LocalOffset = 32'd28800;
  localparam logic [YearW-1:0] BaseYear    = 11'd1970;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } cal_t;

  // leap rule only for years 1970..2039, so 2000 is the one century and it is leap
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  // day count at the start of year BaseYear+k
  // one leap year in every four starting with 1972, which also covers 2000
  function automatic logic [DaysW-1:0] year_start(input logic [YoffW-1:0] k);
    logic [DaysW-1:0] kk;
    kk = DaysW'(k);
    return kk * DaysW'(365) + ((kk + DaysW'(1)) >> 2);
  endfunction

  // day of year at the start of month m (0-based)
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd365;
    endcase
    if (leap && m >= 4'd2) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

>>> src/ep2cal_if.sv
interface ep2cal_in_if;
  logic                         valid;
  logic                         ready;
  logic [ep2cal_pkg::InW-1:0]   epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ep2cal_out_if;
  logic                           valid;
  logic                           ready;
  logic [ep2cal_pkg::YearW-1:0]   year;
  logic [ep2cal_pkg::MonthW-1:0]  month;
  logic [ep2cal_pkg::DayW-1:0]    day;
  logic [ep2cal_pkg::HourW-1:0]   hour;
  logic [ep2cal_pkg::MinW-1:0]    minute;
  logic [ep2cal_pkg::SecW-1:0]    second;
  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day, input hour,
                input minute, input second, output ready);
endinterface

>>> src/ep2cal_tod.sv
// time-of-day stages: offset, then /60, /60, /24 by reciprocal multiply
module ep2cal_tod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [ep2cal_pkg::InW-1:0]    secs_i,
  output logic                          valid_o,
  output logic [ep2cal_pkg::DaysW-1:0]  days_o,
  output logic [ep2cal_pkg::HourW-1:0]  hour_o,
  output logic [ep2cal_pkg::MinW-1:0]   minute_o,
  output logic [ep2cal_pkg::SecW-1:0]   second_o
);
  localparam int unsigned MinsW = 26;
  localparam int unsigned HrsW  = 20;

  logic [3:0]                     vld_q;
  logic [ep2cal_pkg::SecsW-1:0]   secs_q;
  logic [MinsW-1:0]               mins_q;
  logic [HrsW-1:0]                hrs_q;
  logic [ep2cal_pkg::SecW-1:0]    sec1_q, sec2_q;
  logic [ep2cal_pkg::MinW-1:0]    min2_q;
  logic [ep2cal_pkg::DaysW-1:0]   days_q;
  logic [ep2cal_pkg::HourW-1:0]   hour_q;
  logic [ep2cal_pkg::MinW-1:0]    min3_q;
  logic [ep2cal_pkg::SecW-1:0]    sec3_q;

  logic [MinsW-1:0] mins_d;
  logic [HrsW-1:0]  hrs_d;
  logic [ep2cal_pkg::DaysW-1:0] days_d;
  logic [63:0] p1;
  logic [55:0] p2;
  logic [39:0] p3;

  // floor(x/60) = (x * ceil(2^37/60)) >> 37 for x < 2^32
  always_comb begin
    p1     = 64'(secs_q) * 64'd2290649225;
    mins_d = MinsW'(p1 >> 37);
    p2     = 56'(mins_q) * 56'd572662307;
    hrs_d  = HrsW'(p2 >> 35);
    p3     = 40'(hrs_q) * 40'd699051;
    days_d = ep2cal_pkg::DaysW'(p3 >> 24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      secs_q <= ep2cal_pkg::SecsW'(secs_i) + ep2cal_pkg::LocalOffset;
      mins_q <= mins_d;
      sec1_q <= ep2cal_pkg::SecW'(secs_q - ep2cal_pkg::SecsW'(mins_d) * 32'd60);
      hrs_q  <= hrs_d;
      sec2_q <= sec1_q;
      min2_q <= ep2cal_pkg::MinW'(mins_q - MinsW'(hrs_d) * 26'd60);
      days_q <= days_d;
      hour_q <= ep2cal_pkg::HourW'(hrs_q - HrsW'(days_d) * 20'd24);
      min3_q <= min2_q;
      sec3_q <= sec2_q;
    end
  end

  assign valid_o  = vld_q[3];
  assign days_o   = days_q;
  assign hour_o   = hour_q;
  assign minute_o = min3_q;
  assign second_o = sec3_q;
endmodule

>>> src/ep2cal_date.sv
// date stages: year by estimate and correction, then month by table compare
module ep2cal_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [ep2cal_pkg::DaysW-1:0]  days_i,
  input  logic [ep2cal_pkg::HourW-1:0]  hour_i,
  input  logic [ep2cal_pkg::MinW-1:0]   minute_i,
  input  logic [ep2cal_pkg::SecW-1:0]   second_i,
  output logic                          valid_o,
  output ep2cal_pkg::cal_t              cal_o
);
  localparam int unsigned TodW = ep2cal_pkg::HourW + ep2cal_pkg::MinW + ep2cal_pkg::SecW;

  logic [2:0]                     vld_q;
  logic [ep2cal_pkg::DaysW-1:0]   days_q;
  logic [ep2cal_pkg::YoffW-1:0]   yest_q;
  logic [TodW-1:0]                tod1_q, tod2_q, tod3_q;
  logic [ep2cal_pkg::YearW-1:0]   year2_q, year3_q;
  logic [8:0]                     doy_q;
  logic [ep2cal_pkg::MonthW-1:0]  month_q;
  logic [ep2cal_pkg::DayW-1:0]    day_q;

  logic [26:0] pe;
  logic [ep2cal_pkg::YoffW-1:0] yest_d, yoff_d;
  logic [ep2cal_pkg::DaysW-1:0] ys_a, ys_b;
  logic [8:0] doy_d;
  logic leap3;
  logic [3:0] mi;
  logic [8:0] ms;

  // estimate floor(days/365.25) via days*2871 >> 20, then correct by one
  always_comb begin
    pe     = 27'(days_i) * 27'd2871;
    yest_d = ep2cal_pkg::YoffW'(pe >> 20);
    ys_a   = ep2cal_pkg::year_start(yest_q);
    ys_b   = ep2cal_pkg::year_start(yest_q + 7'd1);
    if (days_q >= ys_b) begin
      yoff_d = yest_q + 7'd1;
      doy_d  = 9'(days_q - ys_b);
    end else if (days_q < ys_a) begin
      yoff_d = yest_q - 7'd1;
      doy_d  = 9'(days_q - ep2cal_pkg::year_start(yest_q - 7'd1));
    end else begin
      yoff_d = yest_q;
      doy_d  = 9'(days_q - ys_a);
    end
    leap3 = ep2cal_pkg::is_leap(year2_q);
    mi = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy_q >= ep2cal_pkg::month_start(4'(m), leap3)) begin
        mi = 4'(m);
      end
    end
    ms = ep2cal_pkg::month_start(mi, leap3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      days_q  <= days_i;
      yest_q  <= yest_d;
      tod1_q  <= {hour_i, minute_i, second_i};
      year2_q <= ep2cal_pkg::BaseYear + ep2cal_pkg::YearW'(yoff_d);
      doy_q   <= doy_d;
      tod2_q  <= tod1_q;
      year3_q <= year2_q;
      month_q <= mi + 4'd1;
      day_q   <= ep2cal_pkg::DayW'(doy_q - ms + 9'd1);
      tod3_q  <= tod2_q;
    end
  end

  assign valid_o      = vld_q[2];
  assign cal_o.year   = year3_q;
  assign cal_o.month  = month_q;
  assign cal_o.day    = day_q;
  assign {cal_o.hour, cal_o.minute, cal_o.second} = tod3_q;
endmodule

>>> src/epoch_seconds_to_calendar_unit.sv
// path: a result passes the time-of-day then the date stage registers; an output stall holds it
// throughput: one transfer per cycle; the whole pipeline advances when the
//   output stage is empty or its result is taken, so a stall holds every stage
// stages: offset, /60, /60 and /24 by reciprocal multiply, year estimate and
//   correction, month compare, day of month
// reset: asynchronous active low, clears all valid bits; no clearing pass
module epoch_seconds_to_calendar_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  ep2cal_in_if.sink          in_i,
  ep2cal_out_if.source       out_o
);
  logic adv;
  logic tod_vld, date_vld;
  logic [ep2cal_pkg::DaysW-1:0] days;
  logic [ep2cal_pkg::HourW-1:0] hour;
  logic [ep2cal_pkg::MinW-1:0]  minute;
  logic [ep2cal_pkg::SecW-1:0]  second;
  ep2cal_pkg::cal_t cal;

  // pipeline moves unless the last stage holds a result nobody takes
  assign adv       = !date_vld || out_o.ready;
  assign in_i.ready = adv;

  ep2cal_tod u_tod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_i.valid),
    .secs_i   (in_i.epoch_seconds),
    .valid_o  (tod_vld),
    .days_o   (days),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  ep2cal_date u_date (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (tod_vld),
    .days_i   (days),
    .hour_i   (hour),
    .minute_i (minute),
    .second_i (second),
    .valid_o  (date_vld),
    .cal_o    (cal)
  );

  // result fields straight from the last stage registers
  assign out_o.valid  = date_vld;
  assign out_o.year   = cal.year;
  assign out_o.month  = cal.month;
  assign out_o.day    = cal.day;
  assign out_o.hour   = cal.hour;
  assign out_o.minute = cal.minute;
  assign out_o.second = cal.second;
endmodule

>>> src/ep2cal_checker.sv
module ep2cal_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ep2cal_pkg::MonthW-1:0] month,
  input logic [ep2cal_pkg::DayW-1:0]   day,
  input logic [ep2cal_pkg::HourW-1:0]  hour
);
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  a_free_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input blocked while output empty");
  a_fields_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23)
    else $error("result field out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(month) && $stable(day))
    else $error("stalled result changed");
endmodule

bind epoch_seconds_to_calendar_unit ep2cal_checker u_ep2cal_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .month     (out_o.month),
  .day       (out_o.day),
  .hour      (out_o.hour)
);
